@@ rtl/core/mbrx_pkg.sv @@
// shared types, codes and defaults for the mailbox uart receive ring
package mbrx_pkg;

   localparam int DEF_RX_CAPACITY = 256;
   localparam int DEF_CHUNK_SIZE  = 16;
   localparam int FILL_W          = 9;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_UPPER   = 2'd3;

   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_STATE = 2'd1;

   localparam logic [1:0] RES_ACCEPTED  = 2'd0;
   localparam logic [1:0] RES_MALFORMED = 2'd1;
   localparam logic [1:0] RES_REFUSED   = 2'd2;

   localparam int ST_OVF_BIT = 0;
   localparam int ST_CRC_BIT = 1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  command;
      logic [7:0]  frame_flags;
      logic [7:0]  frame_crc;
      logic [31:0] frame_addr;
      logic [15:0] frame_len;
      logic        link_up;
      logic [7:0]  payload_byte;
      logic        take_status;
      logic        upper_hold;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        reply_bits;
      logic [1:0]        frame_result;
      logic [7:0]        read_data;
      logic              read_valid;
      logic [1:0]        held_status;
      logic              own_stop;
      logic              far_stop;
      logic              far_stop_seen;
      logic [FILL_W-1:0] fill_level;
   } rsp_item_type;

endpackage

@@ rtl/core/mbrx_ring.sv @@
// receive ring byte memory, one write port and one registered read port
module mbrx_ring #(
   parameter int DEPTH  = 257,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] ring_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mbrx_ctrl.sv @@
// ring pointers, reservation, sticky status, rts flags and frame checks
module mbrx_ctrl #(
   parameter int RX_CAPACITY = 256,
   parameter int CHUNK_SIZE  = 16,
   parameter int PTR_W       = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mbrx_pkg::req_item_type item,
   input  logic [31:0]           window_address,
   input  logic [7:0]            rd_data,
   output logic [PTR_W-1:0]      rd_addr,
   output logic                  wr_en,
   output logic [PTR_W-1:0]      wr_addr,
   output logic [7:0]            wr_data,
   output mbrx_pkg::rsp_item_type result
);
   import mbrx_pkg::*;

   localparam int RING_SIZE        = RX_CAPACITY + 1;
   localparam int CNT_W            = PTR_W + 1;
   localparam int STOP_CLEAR_LEVEL = (RX_CAPACITY * 40) / 100;

   logic [PTR_W-1:0] rp_ff, rp_in, wp_ff, wp_in, resv_ff, resv_in;
   logic [1:0]       status_ff, status_in;
   logic             local_ff, local_in, upper_ff, upper_in;
   logic             peer_ff, peer_in, known_ff, known_in;

   logic [PTR_W-1:0] fill, fill_post, rp_next, wp_next;
   logic [CNT_W-1:0] used, used_post;
   logic [CNT_W-1:0] free_now, free_post;
   logic             refresh, failed, malformed;
   logic [7:0]       rdata;
   logic             rvalid;
   logic [1:0]       sticky;

   assign rp_next = (rp_ff == PTR_W'(RING_SIZE - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_next = (wp_ff == PTR_W'(RING_SIZE - 1)) ? '0 : wp_ff + 1'b1;

   always_comb begin
      if (wp_ff >= rp_ff) begin
         fill = wp_ff - rp_ff;
      end else begin
         fill = PTR_W'(CNT_W'(wp_ff) + CNT_W'(RING_SIZE) - CNT_W'(rp_ff));
      end
   end

   assign used     = CNT_W'(fill) + CNT_W'(resv_ff);
   assign free_now = (used >= CNT_W'(RX_CAPACITY)) ? '0 : CNT_W'(RX_CAPACITY) - used;

   always_comb begin
      status_in = status_ff;
      resv_in   = resv_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      upper_in  = upper_ff;
      peer_in   = peer_ff;
      known_in  = known_ff;
      fill_post = fill;
      wr_en     = 1'b0;
      failed    = 1'b0;
      malformed = 1'b0;
      rdata     = '0;
      rvalid    = 1'b0;
      sticky    = '0;
      unique case (item.kind)
         KIND_HEADER: begin
            priority if ((item.command != CMD_DATA && item.command != CMD_STATE)
                         || item.frame_flags[7:1] != '0) begin
               failed    = 1'b1;
               malformed = 1'b1;
            end else if (item.frame_crc != '0) begin
               status_in[ST_CRC_BIT] = 1'b1;
               failed    = 1'b1;
               malformed = 1'b1;
            end else if (item.command == CMD_DATA) begin
               priority if (item.frame_addr != window_address
                            || item.frame_len == '0
                            || 32'(item.frame_len) > 32'(CHUNK_SIZE)) begin
                  failed    = 1'b1;
                  malformed = 1'b1;
               end else if (!item.link_up) begin
                  failed = 1'b1;
               end else if (32'(free_now) < 32'(item.frame_len)) begin
                  status_in[ST_OVF_BIT] = 1'b1;
                  failed = 1'b1;
               end else begin
                  resv_in = resv_ff + PTR_W'(item.frame_len);
               end
            end else if (item.frame_addr != '0 || item.frame_len != '0) begin
               failed    = 1'b1;
               malformed = 1'b1;
            end
            if (!malformed) begin
               peer_in  = item.frame_flags[0];
               known_in = 1'b1;
            end
         end
         KIND_PAYLOAD: begin
            if (resv_ff != '0) begin
               wr_en     = 1'b1;
               wp_in     = wp_next;
               resv_in   = resv_ff - 1'b1;
               fill_post = fill + 1'b1;
            end
         end
         KIND_READ: begin
            if (fill != '0) begin
               rdata     = rd_data;
               rvalid    = 1'b1;
               rp_in     = rp_next;
               fill_post = fill - 1'b1;
            end
            if (item.take_status) begin
               sticky    = status_ff;
               status_in = '0;
            end
         end
         KIND_UPPER: begin
            upper_in = item.upper_hold;
         end
         default: begin
         end
      endcase
   end

   assign used_post = CNT_W'(fill_post) + CNT_W'(resv_in);
   assign free_post = (used_post >= CNT_W'(RX_CAPACITY)) ? '0
                    : CNT_W'(RX_CAPACITY) - used_post;
   assign refresh   = upper_in || (32'(free_post) <= 32'(CHUNK_SIZE));

   always_comb begin
      local_in = local_ff;
      unique case (item.kind)
         KIND_HEADER, KIND_UPPER: local_in = refresh;
         KIND_READ: begin
            if (!upper_ff && local_ff && 32'(fill_post) < 32'(STOP_CLEAR_LEVEL)) begin
               local_in = refresh;
            end
         end
         default: local_in = local_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff     <= '0;
         wp_ff     <= '0;
         resv_ff   <= '0;
         status_ff <= '0;
         local_ff  <= 1'b0;
         upper_ff  <= 1'b0;
         peer_ff   <= 1'b0;
         known_ff  <= 1'b0;
      end else if (step) begin
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         resv_ff   <= resv_in;
         status_ff <= status_in;
         local_ff  <= local_in;
         upper_ff  <= upper_in;
         peer_ff   <= peer_in;
         known_ff  <= known_in;
      end
   end

   assign rd_addr = rp_ff;
   assign wr_addr = wp_ff;
   assign wr_data = item.payload_byte;

   always_comb begin
      result.reply_bits    = (item.kind == KIND_HEADER) ? {failed, local_in} : 2'b00;
      result.frame_result  = malformed ? RES_MALFORMED
                           : (failed ? RES_REFUSED : RES_ACCEPTED);
      result.read_data     = rdata;
      result.read_valid    = rvalid;
      result.held_status   = sticky;
      result.own_stop      = local_in;
      result.far_stop      = peer_in;
      result.far_stop_seen = known_in;
      result.fill_level    = FILL_W'(fill_post);
   end

endmodule

@@ rtl/core/mailbox_uart_rx_ring_flow_control_core.sv @@
// mailbox uart receive core: frame checks, payload ring and rts flow control
// flow: a taken request word waits in stage one for the ring read issued at accept;
// stage one steps once no shown response is stalled, updating pointers and flags and
// registering the result word; no new request is taken while stage one is full
// reset: synchronous; pointers, reservation, status and rts flags clear, ring
// contents stay undefined until written, window address clears to zero
module mailbox_uart_rx_ring_flow_control_core #(
   parameter int RX_CAPACITY = mbrx_pkg::DEF_RX_CAPACITY,
   parameter int CHUNK_SIZE  = mbrx_pkg::DEF_CHUNK_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [1:0]                    req_command,
   input  logic [7:0]                    req_frame_flags,
   input  logic [7:0]                    req_frame_crc,
   input  logic [31:0]                   req_frame_addr,
   input  logic [15:0]                   req_frame_len,
   input  logic                          req_link_up,
   input  logic [7:0]                    req_payload_byte,
   input  logic                          req_take_status,
   input  logic                          req_upper_hold,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_reply_bits,
   output logic [1:0]                    rsp_frame_result,
   output logic [7:0]                    rsp_read_data,
   output logic                          rsp_read_valid,
   output logic [1:0]                    rsp_held_status,
   output logic                          rsp_own_stop,
   output logic                          rsp_far_stop,
   output logic                          rsp_far_stop_seen,
   output logic [mbrx_pkg::FILL_W-1:0]   rsp_fill_level
);
   import mbrx_pkg::*;

   localparam int RING_SIZE = RX_CAPACITY + 1;
   localparam int PTR_W     = $clog2(RING_SIZE);

   logic [31:0]  window_ff;
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   req_item_type req_item;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         accept, step;

   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic [7:0]       rd_data, wr_data;
   logic             wr_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_wdata;
      end
   end

   assign req_item.kind         = req_kind;
   assign req_item.command      = req_command;
   assign req_item.frame_flags  = req_frame_flags;
   assign req_item.frame_crc    = req_frame_crc;
   assign req_item.frame_addr   = req_frame_addr;
   assign req_item.frame_len    = req_frame_len;
   assign req_item.link_up      = req_link_up;
   assign req_item.payload_byte = req_payload_byte;
   assign req_item.take_status  = req_take_status;
   assign req_item.upper_hold   = req_upper_hold;

   assign req_stall = s1_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign step      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   mbrx_ring #(
      .DEPTH  (RING_SIZE),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en && step),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mbrx_ctrl #(
      .RX_CAPACITY (RX_CAPACITY),
      .CHUNK_SIZE  (CHUNK_SIZE),
      .PTR_W       (PTR_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (s1_item_ff),
      .window_address (window_ff),
      .rd_data        (rd_data),
      .rd_addr        (rd_addr),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .result         (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_bits    = rsp_item_ff.reply_bits;
   assign rsp_frame_result  = rsp_item_ff.frame_result;
   assign rsp_read_data     = rsp_item_ff.read_data;
   assign rsp_read_valid    = rsp_item_ff.read_valid;
   assign rsp_held_status   = rsp_item_ff.held_status;
   assign rsp_own_stop      = rsp_item_ff.own_stop;
   assign rsp_far_stop      = rsp_item_ff.far_stop;
   assign rsp_far_stop_seen = rsp_item_ff.far_stop_seen;
   assign rsp_fill_level    = rsp_item_ff.fill_level;

endmodule
